### hdl/ins_pkg.sv
// ----------------------------------------------------------------------------
// ins_pkg
// Shared constants and controller/datapath command and status types for the
// insertion sorter.
// ----------------------------------------------------------------------------
package ins_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int VALUE_W       = 32;

   // controller -> datapath
   typedef struct packed {
      logic insert;   // place the incoming word into the sorted row
      logic pop;      // shift the row toward the head by one cell
   } ins_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;       // every cell holds a word
      logic one_left;   // only the head cell holds a word
      logic head_valid; // head cell holds a word
   } ins_status_type;

endpackage

### hdl/ins_chan_if.sv
// ----------------------------------------------------------------------------
// ins_req_if / ins_rsp_if
// Valid/ready channels of the insertion sorter: unsorted words in, sorted
// words out.
// ----------------------------------------------------------------------------
interface ins_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [ins_pkg::VALUE_W-1:0] value;
   logic                              last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface ins_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [ins_pkg::VALUE_W-1:0] value_res;
   logic                              last_res;
   logic                              overflow;

   modport source (output valid, output value_res, output last_res, output overflow,
                   input ready);
   modport sink   (input valid, input value_res, input last_res, input overflow,
                   output ready);
endinterface

### hdl/insertion_sorter.sv
// Insertion sorter: stable ascending sort of signed words, one set at a time.
// Collection: one word accepted per cycle; each insert is written into the row at the clock edge that accepts it.
// Drain: starts the cycle after the last word; results leave in order, held while rsp_ready is low,
// and no input is taken until the last result has left.
// Reset (synchronous, active high) empties the row and clears the drop flag;
// the cell contents themselves are not cleared.
// ----------------------------------------------------------------------------
// insertion_sorter
// Top level: controller plus a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module insertion_sorter #(
   parameter int DEPTH = ins_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ins_req_if.sink    req_ch,
   ins_rsp_if.source  rsp_ch
);
   import ins_pkg::*;

   ins_cmd_type    cmd;
   ins_status_type status;

   ins_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .overflow  (rsp_ch.overflow),
      .cmd       (cmd)
   );

   ins_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .value  (req_ch.value),
      .status (status),
      .head   (rsp_ch.value_res)
   );

   assign rsp_ch.last_res = status.one_left;

   // a result is only offered from an occupied head cell
   a_rsp_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> status.head_valid)
      else $error("result offered from an empty row");

   // never insert into a full row
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !status.full)
      else $error("insert into a full row");

   // collection and drain never overlap
   a_phases_apart: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input and output open at once");

   // after the final word of a run the row is empty and the drop flag is cleared
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_res)
         |=> (!status.head_valid && req_ch.ready && !rsp_ch.overflow))
      else $error("state not cleared after run");

endmodule

### hdl/ins_datapath.sv
// ----------------------------------------------------------------------------
// ins_datapath
// Row of sorting cells. Each cell compares its word against the incoming one
// in parallel; on insert the larger words move one cell up and the new word
// drops into the gap. On pop the row shifts toward the head.
// ----------------------------------------------------------------------------
module ins_datapath #(
   parameter int DEPTH = ins_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ins_pkg::ins_cmd_type               cmd,
   input  logic signed [ins_pkg::VALUE_W-1:0] value,
   output ins_pkg::ins_status_type            status,
   output logic signed [ins_pkg::VALUE_W-1:0] head
);
   import ins_pkg::*;

   logic signed [VALUE_W-1:0] cells_ff [DEPTH];
   logic signed [VALUE_W-1:0] cells_in [DEPTH];
   logic [DEPTH-1:0]          occ_ff;
   logic [DEPTH-1:0]          occ_in;
   logic [DEPTH-1:0]          gt;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_val;
      logic signed [VALUE_W-1:0] next_val;
      logic                      prev_gt;
      logic                      prev_occ;
      logic                      next_occ;

      // strictly greater keeps equal words ahead of the new one
      assign gt[g] = occ_ff[g] && (cells_ff[g] > value);

      if (g == 0) begin : g_head
         assign prev_val = '0;
         assign prev_gt  = 1'b0;
         assign prev_occ = 1'b1;
      end else begin : g_body
         assign prev_val = cells_ff[g-1];
         assign prev_gt  = gt[g-1];
         assign prev_occ = occ_ff[g-1];
      end

      if (g == DEPTH-1) begin : g_tail
         assign next_val = '0;
         assign next_occ = 1'b0;
      end else begin : g_mid
         assign next_val = cells_ff[g+1];
         assign next_occ = occ_ff[g+1];
      end

      always_comb begin
         cells_in[g] = cells_ff[g];
         occ_in[g]   = occ_ff[g];
         if (cmd.insert) begin
            if (prev_gt) begin
               cells_in[g] = prev_val;
            end else if (gt[g] || !occ_ff[g]) begin
               cells_in[g] = value;
            end
            occ_in[g] = occ_ff[g] | prev_occ;
         end else if (cmd.pop) begin
            cells_in[g] = next_val;
            occ_in[g]   = next_occ;
         end
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign status.full       = occ_ff[DEPTH-1];
   assign status.one_left   = occ_ff[0] && !occ_ff[1];
   assign status.head_valid = occ_ff[0];
   assign head              = cells_ff[0];

endmodule

### hdl/ins_ctrl.sv
// ----------------------------------------------------------------------------
// ins_ctrl
// Controller: collects a set, then drains it in order. Tracks whether any
// word of the current set was dropped.
// ----------------------------------------------------------------------------
module ins_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   input  logic                    rsp_ready,
   input  ins_pkg::ins_status_type status,
   output logic                    req_ready,
   output logic                    rsp_valid,
   output logic                    overflow,
   output ins_pkg::ins_cmd_type    cmd
);
   import ins_pkg::*;

   typedef enum logic {
      COLLECT,
      DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      dropped_ff, dropped_in;
   logic      req_fire;

   assign req_ready  = (state_ff == COLLECT);
   assign rsp_valid  = (state_ff == DRAIN);
   assign overflow   = dropped_ff;
   assign req_fire   = req_valid && req_ready;
   assign cmd.insert = req_fire && !status.full;
   assign cmd.pop    = rsp_valid && rsp_ready;

   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         COLLECT: begin
            // drop the word when the row is full
            if (req_fire && status.full) dropped_in = 1'b1;
            if (req_fire && req_last) state_in = DRAIN;
         end
         DRAIN: begin
            if (cmd.pop && status.one_left) begin
               state_in   = COLLECT;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in   = COLLECT;
            dropped_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= COLLECT;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule
